@@ rtl/tsrm_pkg.sv @@
// Package of shared types and constants for the three-wire serial register master.
`default_nettype none

package tsrm_pkg;

	localparam int ADDR_IN_W  = 7;
	localparam int DATA_IN_W  = 16;
	localparam int PHASE_W    = 16;
	localparam int READ_W     = 16;

	typedef enum logic [1:0] {
		PH_LOW1 = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW2 = 2'd2
	} phase_t;

	typedef struct packed {
		logic                 start_req;
		logic                 mode;
		logic                 chip_select;
		logic [ADDR_IN_W-1:0] address;
		logic [DATA_IN_W-1:0] write_data;
		logic                 data_in_pin;
	} in_item_t;

	typedef struct packed {
		logic              clock_pin;
		logic              data_out_pin;
		logic              data_drive_enable;
		logic              enable_first_n;
		logic              enable_second_n;
		logic              busy_res;
		logic [READ_W-1:0] read_data;
		logic              done_res;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/tsrm_if.sv @@
// Valid/ready channel interfaces for the tick input and the pin-level result.
`default_nettype none

interface tsrm_in_if;
	logic               valid;
	logic               ready;
	tsrm_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tsrm_out_if;
	logic                valid;
	logic                ready;
	tsrm_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/three_wire_spi_register_master.sv @@
// Top level of the three-wire serial register master: channels, input and result registers.
//
// Usage. Every transfer on in_ch is one timing tick of the serial bus. A tick with start_req
// set while the master is idle latches a command (mode, chip_select, address, write_data) and
// opens a frame: idle pulse, enable pulse, read/write bit, address bits, then either the write
// bits or a turnaround pulse and the read bits, and a closing pulse. Each pulse is three
// phases of phase_ticks ticks. Starts that arrive during a frame are dropped.
// Every input transfer yields exactly one result transfer on out_ch carrying the pin levels
// for that tick, busy and done flags and the last read value.
// data_in_pin is sampled on the last tick of each read pulse.
// Path: a tick accepted on in_ch is held in the input register, and its result is then
// registered in the output register. Throughput: one tick per clock while out_ch.ready
// stays high; the sequencer state takes a single-step update per tick.
// Stalls: when out_ch.ready is low the result holds, the input register keeps its tick, and
// in_ch.ready drops once both are full; no tick is lost or repeated.
// Reset: arst_n clears the sequencer to idle, empties both registers and sets phase_ticks to
// one. The user must write phase_ticks (cfg_we/cfg_wdata) while no tick is in flight; not enforced.
`default_nettype none

module three_wire_spi_register_master #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	tsrm_in_if.sink                           in_ch,
	tsrm_out_if.source                        out_ch,
	input  wire logic                         cfg_we,
	input  wire logic [tsrm_pkg::PHASE_W-1:0] cfg_wdata
);

	logic                          s1_valid_q;
	tsrm_pkg::in_item_t            item_s1;
	logic                          out_valid_q;
	tsrm_pkg::out_item_t           result_q;
	tsrm_pkg::out_item_t           result_c;
	logic [tsrm_pkg::PHASE_W-1:0]  phase_ticks_q;
	logic                          advance;
	logic                          step;

	// The result register frees up whenever it is empty or being taken this cycle.
	assign advance      = !out_valid_q || out_ch.ready;
	assign step         = s1_valid_q && advance;
	assign in_ch.ready  = !s1_valid_q || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= tsrm_pkg::PHASE_W'(1);
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// Input register: holds one tick until the sequencer can consume it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.payload;
		end
	end

	tsrm_core #(
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (DATA_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.result      (result_c)
	);

	// Result register: the pin levels for the tick just processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_c;
		end
	end

	// A held tick must not vanish while the output side is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q)
		else $error("input tick dropped during output stall");

	// Both device enables are never asserted together.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.enable_first_n || result_q.enable_second_n))
		else $error("both device enables asserted");

	// Done only appears inside a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.done_res |-> result_q.busy_res)
		else $error("done raised outside a frame");

	// A released data pin is driven low and occurs only with a device enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.data_drive_enable |->
			!result_q.data_out_pin && (!result_q.enable_first_n || !result_q.enable_second_n))
		else $error("data pin released outside the read phase");

endmodule

`default_nettype wire

@@ rtl/tsrm_core.sv @@
// Frame sequencer: advances the bus state by one tick and forms that tick's pin levels.
`default_nettype none

module tsrm_core #(
	parameter int ADDR_BITS = 7,
	parameter int DATA_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire tsrm_pkg::in_item_t               item,
	input  wire logic [tsrm_pkg::PHASE_W-1:0]     phase_ticks,
	output tsrm_pkg::out_item_t                   result
);

	localparam int TX_W      = 1 + ADDR_BITS + DATA_BITS;
	localparam int PW        = $clog2(6 + ADDR_BITS + DATA_BITS);
	localparam logic [PW-1:0] P_ONE      = PW'(1);
	localparam logic [PW-1:0] P_MODE     = PW'(2);
	localparam logic [PW-1:0] P_TURN     = PW'(3 + ADDR_BITS);
	localparam logic [PW-1:0] P_FIRST_RD = PW'(4 + ADDR_BITS);
	localparam logic [PW-1:0] P_LASTBIT  = PW'(2 + ADDR_BITS + DATA_BITS);
	localparam logic [PW-1:0] P_CLOSE_WR = PW'(3 + ADDR_BITS + DATA_BITS);
	localparam logic [PW-1:0] P_CLOSE_RD = PW'(4 + ADDR_BITS + DATA_BITS);

	logic                            active_q;
	logic                            mode_q;
	logic                            chip_q;
	logic [PW-1:0]                   pulse_q;
	tsrm_pkg::phase_t                phase_q;
	logic [tsrm_pkg::PHASE_W-1:0]    timer_q;
	logic [TX_W-1:0]                 tx_q;
	logic [DATA_BITS-1:0]            shift_q;
	logic [tsrm_pkg::READ_W-1:0]     read_q;

	logic [ADDR_BITS-1:0]            addr_ext;
	logic [DATA_BITS-1:0]            data_ext;
	logic [tsrm_pkg::READ_W-1:0]     shin_ext;

	logic                            start;
	logic                            act;
	logic                            mode_c;
	logic                            chip_c;
	logic [PW-1:0]                   pulse_c;
	tsrm_pkg::phase_t                phase_c;
	tsrm_pkg::phase_t                phase_inc;
	logic [tsrm_pkg::PHASE_W-1:0]    timer_c;
	logic [TX_W-1:0]                 tx_c;
	logic [DATA_BITS-1:0]            shin_c;
	logic [PW-1:0]                   closing;
	logic [tsrm_pkg::PHASE_W-1:0]    len;
	logic                            last_tick;
	logic                            pulse_end;
	logic                            finish;
	logic                            sample;
	logic                            shift_tx;
	logic                            en_on;
	logic                            release_pin;

	// Command fields resized to the frame widths: extra bits dropped, missing ones zero.
	for (genvar i = 0; i < ADDR_BITS; i++) begin : g_addr
		if (i < tsrm_pkg::ADDR_IN_W) begin : g_take
			assign addr_ext[i] = item.address[i];
		end else begin : g_zero
			assign addr_ext[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < DATA_BITS; i++) begin : g_data
		if (i < tsrm_pkg::DATA_IN_W) begin : g_take
			assign data_ext[i] = item.write_data[i];
		end else begin : g_zero
			assign data_ext[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < tsrm_pkg::READ_W; i++) begin : g_read
		if (i < DATA_BITS) begin : g_take
			assign shin_ext[i] = shin_c[i];
		end else begin : g_zero
			assign shin_ext[i] = 1'b0;
		end
	end

	// A start on an idle tick takes effect on the same tick as the first idle-pulse tick.
	assign start   = item.start_req && !active_q;
	assign act     = active_q || start;
	assign mode_c  = start ? item.mode : mode_q;
	assign chip_c  = start ? item.chip_select : chip_q;
	assign pulse_c = start ? '0 : pulse_q;
	assign phase_c = start ? tsrm_pkg::PH_LOW1 : phase_q;
	assign timer_c = start ? '0 : timer_q;
	assign tx_c    = start ? {item.mode, addr_ext, data_ext} : tx_q;
	assign shin_c  = start ? '0 : shift_q;

	assign closing   = mode_c ? P_CLOSE_RD : P_CLOSE_WR;
	assign len       = (phase_ticks == '0) ? tsrm_pkg::PHASE_W'(1) : phase_ticks;
	assign last_tick = ({1'b0, timer_c} + 17'd1) >= {1'b0, len};
	assign pulse_end = act && last_tick && (phase_c == tsrm_pkg::PH_LOW2);
	assign finish    = pulse_end && (pulse_c == closing);
	assign sample    = mode_c && pulse_end && (pulse_c >= P_FIRST_RD) && (pulse_c < closing);
	assign shift_tx  = pulse_end && (pulse_c >= P_MODE) && (pulse_c < P_LASTBIT);
	assign en_on     = (pulse_c >= P_ONE) && (pulse_c < closing);
	assign release_pin = mode_c && (pulse_c >= P_TURN) && (pulse_c < closing);

	always_comb begin
		unique case (phase_c)
			tsrm_pkg::PH_LOW1: phase_inc = tsrm_pkg::PH_HIGH;
			tsrm_pkg::PH_HIGH: phase_inc = tsrm_pkg::PH_LOW2;
			default:           phase_inc = tsrm_pkg::PH_LOW1;
		endcase
	end

	always_comb begin
		result                   = '0;
		result.data_drive_enable = 1'b1;
		result.enable_first_n    = 1'b1;
		result.enable_second_n   = 1'b1;
		result.read_data         = (finish && mode_c) ? shin_ext : read_q;
		if (act) begin
			result.busy_res          = 1'b1;
			result.done_res          = finish;
			result.clock_pin         = (phase_c == tsrm_pkg::PH_HIGH);
			result.enable_first_n    = !(en_on && !chip_c);
			result.enable_second_n   = !(en_on && chip_c);
			result.data_drive_enable = !release_pin;
			// Address and write bits come off the top of the transmit register; a read
			// drives nothing from the turnaround pulse on.
			result.data_out_pin      = (pulse_c >= P_MODE) && !(mode_c && pulse_c >= P_TURN)
				&& tx_c[TX_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mode_q   <= 1'b0;
			chip_q   <= 1'b0;
			pulse_q  <= '0;
			phase_q  <= tsrm_pkg::PH_LOW1;
			timer_q  <= '0;
			tx_q     <= '0;
			shift_q  <= '0;
			read_q   <= '0;
		end else if (step && act) begin
			active_q <= !finish;
			mode_q   <= mode_c;
			chip_q   <= chip_c;
			timer_q  <= last_tick ? '0 : timer_c + tsrm_pkg::PHASE_W'(1);
			phase_q  <= last_tick ? phase_inc : phase_c;
			if (pulse_end) begin
				pulse_q <= finish ? '0 : pulse_c + P_ONE;
			end else begin
				pulse_q <= pulse_c;
			end
			tx_q    <= shift_tx ? {tx_c[TX_W-2:0], 1'b0} : tx_c;
			shift_q <= sample ? ((shin_c << 1) | DATA_BITS'(item.data_in_pin)) : shin_c;
			if (finish && mode_c) begin
				read_q <= shin_ext;
			end
		end
	end

endmodule

`default_nettype wire
